// File: rtl/npcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, command codes and constants of the nearest palette color
// matcher.
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int COLOR_W = 8;
    localparam int ENTRY_W = 3 * COLOR_W;
    localparam int INDEX_W = 4;
    localparam int DIST_W  = 23;
    localparam int REV_W   = 32;
    localparam int SQ_W    = 2 * COLOR_W;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;

    localparam logic [6:0] WEIGHT_R = 7'd30;
    localparam logic [6:0] WEIGHT_G = 7'd59;
    localparam logic [6:0] WEIGHT_B = 7'd11;

    localparam logic [REV_W-1:0] REV_RESET = 32'd1;

    // Default sixteen-color table, packed red, green, blue.
    localparam logic [ENTRY_W-1:0] DEFAULT_COLORS [16] = '{
        24'h000000, 24'hFFFFFF, 24'hBE1A24, 24'h30E6C6,
        24'hB41AE2, 24'h1FD21E, 24'h211BAE, 24'hDFF60A,
        24'hB84104, 24'h6A3304, 24'hFE4A57, 24'h424540,
        24'h70746F, 24'h59FE59, 24'h5553FE, 24'hA4A7A2
    };

    // Control tag that rides along the scoring pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_tag;

    // Reset content of a palette entry; entries past the table are black.
    function automatic logic [ENTRY_W-1:0] default_color(input logic [7:0] idx);
        logic [ENTRY_W-1:0] val;
        val = '0;
        if (idx < 8'd16) begin
            val = DEFAULT_COLORS[idx[3:0]];
        end
        return val;
    endfunction

endpackage
`default_nettype wire

// File: rtl/npcm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_in_if / npcm_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface npcm_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       load_last;

    modport source (output valid, command, entry_index, red, green, blue, load_last,
                    input ready);
    modport sink   (input valid, command, entry_index, red, green, blue, load_last,
                    output ready);
endinterface

interface npcm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  color_index;
    logic [22:0] best_distance;
    logic [31:0] revision;

    modport source (output valid, color_index, best_distance, revision, input ready);
    modport sink   (input valid, color_index, best_distance, revision, output ready);
endinterface
`default_nettype wire

// File: rtl/npcm_palette_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_palette_mem
// Palette storage: one write port, one synchronous (registered) read port.
// Per-entry valid bits stand in for the default table until written.
// ----------------------------------------------------------------------------
module npcm_palette_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [npcm_pkg::ENTRY_W-1:0] o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [npcm_pkg::ENTRY_W-1:0] i_wr_data
);
    import npcm_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_hit;
    logic [AW-1:0]      r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_hit  <= r_vld[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : default_color(8'(r_rd_addr));

endmodule
`default_nettype wire

// File: rtl/npcm_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_score
// Two-stage weighted distance unit: squares of the channel differences,
// then 30*dr^2 + 59*dg^2 + 11*db^2. Takes one entry per cycle.
// ----------------------------------------------------------------------------
module npcm_score #(
    parameter int AW = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  npcm_pkg::t_tag                   i_tag,
    input  wire logic [AW-1:0]               i_idx,
    input  wire logic [npcm_pkg::ENTRY_W-1:0] i_entry,
    input  wire logic [npcm_pkg::COLOR_W-1:0] i_red,
    input  wire logic [npcm_pkg::COLOR_W-1:0] i_green,
    input  wire logic [npcm_pkg::COLOR_W-1:0] i_blue,
    output npcm_pkg::t_tag                   o_tag,
    output logic      [AW-1:0]               o_idx,
    output logic      [npcm_pkg::DIST_W-1:0]  o_dist
);
    import npcm_pkg::*;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [COLOR_W-1:0] dr, dg, db;
    t_tag               r_tag1, r_tag2;
    logic [AW-1:0]      r_idx1, r_idx2;
    logic [SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;
    logic [DIST_W-1:0]  r_dist;

    assign dr = abs_diff(i_entry[3*COLOR_W-1:2*COLOR_W], i_red);
    assign dg = abs_diff(i_entry[2*COLOR_W-1:COLOR_W], i_green);
    assign db = abs_diff(i_entry[COLOR_W-1:0], i_blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_sq_r <= SQ_W'(dr) * SQ_W'(dr);
        r_sq_g <= SQ_W'(dg) * SQ_W'(dg);
        r_sq_b <= SQ_W'(db) * SQ_W'(db);
        r_idx2 <= r_idx1;
        r_dist <= DIST_W'(WEIGHT_R) * DIST_W'(r_sq_r)
                + DIST_W'(WEIGHT_G) * DIST_W'(r_sq_g)
                + DIST_W'(WEIGHT_B) * DIST_W'(r_sq_b);
    end

    assign o_tag  = r_tag2;
    assign o_idx  = r_idx2;
    assign o_dist = r_dist;

endmodule
`default_nettype wire

// File: rtl/nearest_palette_color_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_matcher_top
// Palette of PALETTE_SIZE RGB entries with load and nearest-color query.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command words. A load (command 0) writes one palette entry;
//   the word with load_last closes the load and bumps the revision if any
//   entry of that load changed (wraps to 1, never 0). A query (command 1)
//   returns the lowest-index entry with the smallest weighted distance.
//   o_out returns exactly one result word per command word, in order, each
//   with the current revision.
// Flow:
//   Load: S_LD_RD (read), S_LD_WR (compare/write), then S_DONE (emit).
//   Query: one palette read per cycle feeds the shared two-stage distance
//   unit, whose output updates the running minimum before S_DONE emits.
//   One word is in flight at a time; i_in.ready is high only when idle.
// Reset: the palette reads as the default table, revision is 1.
// Stall: a finished result waits in the output register; the next word is
//   still taken and runs until its own result needs that register.
// ----------------------------------------------------------------------------
module nearest_palette_color_matcher_top #(
    parameter int PALETTE_SIZE = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    npcm_in_if.sink   i_in,
    npcm_out_if.source o_out
);
    import npcm_pkg::*;

    localparam int AW = $clog2(PALETTE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_SIZE - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LD_RD = 6'b000010,
        S_LD_WR = 6'b000100,
        S_Q_RUN = 6'b001000,
        S_Q_WT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state, n_state;

    // captured command word
    logic               r_cmd;
    logic [INDEX_W-1:0] r_idx;
    logic [COLOR_W-1:0] r_red, r_green, r_blue;
    logic               r_last;

    logic [AW-1:0]      r_cnt, n_cnt;
    t_tag               r_rd_tag, n_rd_tag;
    logic [AW-1:0]      r_rd_idx;

    logic [REV_W-1:0]   r_rev, n_rev;
    logic               r_chg, n_chg;
    logic [DIST_W-1:0]  r_best;
    logic [AW-1:0]      r_best_idx;

    logic               r_out_vld;
    logic [INDEX_W-1:0] r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;
    logic [REV_W-1:0]   r_out_rev;

    logic               in_acc;
    logic               in_range;
    logic               out_free;
    logic [ENTRY_W-1:0] ld_value;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, ld_addr;
    logic [ENTRY_W-1:0] rd_data;
    t_tag               sc_tag;
    logic [AW-1:0]      sc_idx;
    logic [DIST_W-1:0]  sc_dist;
    logic [REV_W-1:0]   rev_inc;
    logic               chg_now;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;

    assign in_range = 32'(r_idx) < 32'(PALETTE_SIZE);
    assign ld_addr  = AW'(r_idx);
    assign ld_value = {r_red, r_green, r_blue};
    assign chg_now  = in_range && (rd_data != ld_value);
    assign rev_inc  = r_rev + REV_W'(1);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rd_tag = '0;
        n_rev    = r_rev;
        n_chg    = r_chg;
        rd_en    = 1'b0;
        rd_addr  = r_cnt;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.command == CMD_QUERY) ? S_Q_RUN : S_LD_RD;
                end
            end
            S_LD_RD: begin
                rd_en   = in_range;
                rd_addr = ld_addr;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                wr_en = in_range;
                n_chg = r_chg | chg_now;
                if (r_last) begin
                    if (n_chg) begin
                        n_rev = (rev_inc == '0) ? REV_RESET : rev_inc;
                    end
                    n_chg = 1'b0;
                end
                n_state = S_DONE;
            end
            S_Q_RUN: begin
                rd_en          = 1'b1;
                n_rd_tag.vld   = 1'b1;
                n_rd_tag.first = (r_cnt == '0);
                n_rd_tag.last  = (r_cnt == LAST_IDX);
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = S_Q_WT;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_Q_WT: begin
                if (sc_tag.vld && sc_tag.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rd_tag  <= '0;
            r_rev     <= REV_RESET;
            r_chg     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_tag <= n_rd_tag;
            r_rev    <= n_rev;
            r_chg    <= n_chg;
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_in.command;
            r_idx   <= i_in.entry_index;
            r_red   <= i_in.red;
            r_green <= i_in.green;
            r_blue  <= i_in.blue;
            r_last  <= i_in.load_last;
        end
        r_rd_idx <= r_cnt;
        // first score seeds the minimum; strict less keeps the lowest index
        if (sc_tag.vld && (sc_tag.first || sc_dist < r_best)) begin
            r_best     <= sc_dist;
            r_best_idx <= sc_idx;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_idx  <= (r_cmd == CMD_QUERY) ? INDEX_W'(r_best_idx) : '0;
            r_out_dist <= (r_cmd == CMD_QUERY) ? r_best : '0;
            r_out_rev  <= r_rev;
        end
    end

    npcm_palette_mem #(
        .DEPTH (PALETTE_SIZE),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (ld_addr),
        .i_wr_data (ld_value)
    );

    npcm_score #(
        .AW (AW)
    ) u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_idx   (r_rd_idx),
        .i_entry (rd_data),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_tag   (sc_tag),
        .o_idx   (sc_idx),
        .o_dist  (sc_dist)
    );

    assign o_out.valid         = r_out_vld;
    assign o_out.color_index   = r_out_idx;
    assign o_out.best_distance = r_out_dist;
    assign o_out.revision      = r_out_rev;

endmodule
`default_nettype wire

// File: tb/npcm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npcm_checker
// Watches the command and result channels of the nearest palette color
// matcher. Keeps its own palette, revision and load state, predicts one
// result word per accepted command word and compares every accepted result
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module npcm_checker #(
    parameter int PALETTE_SIZE = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    npcm_in_if        i_cmd,
    npcm_out_if       i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import npcm_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] color_index;
        logic [DIST_W-1:0]  best_distance;
        logic [REV_W-1:0]   revision;
    } t_npcm_result;

    localparam int SHOW_MAX = 10;

    logic [ENTRY_W-1:0] palette_q [PALETTE_SIZE];
    logic [REV_W-1:0]   revision_q;
    logic               load_dirty_q;
    t_npcm_result       expected_results [$];
    int                 results_seen;

    function automatic int weighted_distance(input logic [ENTRY_W-1:0] entry,
                                             input logic [7:0] r,
                                             input logic [7:0] g,
                                             input logic [7:0] b);
        int dr;
        int dg;
        int db;
        dr = (entry[23:16] > r) ? int'(entry[23:16] - r) : int'(r - entry[23:16]);
        dg = (entry[15:8] > g) ? int'(entry[15:8] - g) : int'(g - entry[15:8]);
        db = (entry[7:0] > b) ? int'(entry[7:0] - b) : int'(b - entry[7:0]);
        return int'(WEIGHT_R) * dr * dr + int'(WEIGHT_G) * dg * dg
             + int'(WEIGHT_B) * db * db;
    endfunction

    // Applies one command word to the shadow state and returns its result.
    task automatic step_palette(input logic cmd, input logic [3:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic last,
                                output t_npcm_result res);
        logic [ENTRY_W-1:0] value;
        int best;
        int d;
        res = '0;
        if (cmd == CMD_QUERY) begin
            best = weighted_distance(palette_q[0], r, g, b);
            for (int i = 1; i < PALETTE_SIZE; i++) begin
                d = weighted_distance(palette_q[i], r, g, b);
                // strict compare: lowest index keeps a tie
                if (d < best) begin
                    best = d;
                    res.color_index = INDEX_W'(i);
                end
            end
            res.best_distance = DIST_W'(best);
        end else begin
            value = {r, g, b};
            if (int'(idx) < PALETTE_SIZE) begin
                if (palette_q[idx] != value) begin
                    load_dirty_q = 1'b1;
                end
                palette_q[idx] = value;
            end
            if (last) begin
                if (load_dirty_q) begin
                    revision_q = revision_q + 1'b1;
                    if (revision_q == '0) begin
                        revision_q = 32'd1;
                    end
                end
                load_dirty_q = 1'b0;
            end
        end
        res.revision = revision_q;
    endtask

    always @(posedge i_clk) begin : track
        t_npcm_result got;
        t_npcm_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                palette_q[i] = (i < 16) ? DEFAULT_COLORS[i % 16] : '0;
            end
            revision_q   = REV_RESET;
            load_dirty_q = 1'b0;
            expected_results.delete();
            results_seen = 0;
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            // result side first: a word accepted now cannot be answered now
            if (i_res.valid && i_res.ready) begin
                got.color_index   = i_res.color_index;
                got.best_distance = i_res.best_distance;
                got.revision      = i_res.revision;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < SHOW_MAX) begin
                        $display({"unexpected result word: color_index %0d ",
                                  "best_distance %0d revision %0d"},
                                 got.color_index, got.best_distance, got.revision);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (o_fail_count < SHOW_MAX) begin
                            $display({"mismatch on result %0d: ",
                                      "color_index exp %0d got %0d, ",
                                      "best_distance exp %0d got %0d, ",
                                      "revision exp %0d got %0d"},
                                     results_seen, want.color_index, got.color_index,
                                     want.best_distance, got.best_distance,
                                     want.revision, got.revision);
                        end
                        o_fail_count++;
                    end
                end
                results_seen++;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                step_palette(i_cmd.command, i_cmd.entry_index, i_cmd.red, i_cmd.green,
                             i_cmd.blue, i_cmd.load_last, want);
                expected_results.push_back(want);
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the nearest palette color matcher testbench. Drives directed and
// random load/query words with random gaps on both channels, holds the
// result side off for long stretches so the block backs up, and gives the
// verdict from the checker's failure count and pending count.
// ----------------------------------------------------------------------------
module tb;
    import npcm_pkg::*;

    localparam int PALETTE_SIZE    = 16;
    localparam int N_RANDOM        = 850;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRESSURE_CYCLES = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   words_sent = 0;
    bit   no_gaps    = 1'b0;
    int   fail_count;
    int   pending;

    npcm_in_if  cmd_ch ();
    npcm_out_if res_ch ();

    nearest_palette_color_matcher_top #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    npcm_checker #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 4);
        if (sel < 97) return $urandom_range(5, 15);
        return $urandom_range(20, 60);
    endfunction

    // channel value, biased toward the extremes
    function automatic logic [7:0] pick_level();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_word(input logic cmd, input logic [3:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic last);
        int gap;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.entry_index <= idx;
        cmd_ch.red         <= r;
        cmd_ch.green       <= g;
        cmd_ch.blue        <= b;
        cmd_ch.load_last   <= last;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        words_sent++;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random bursts and gaps, plus long hold-offs
    initial begin : rx_proc
        int run_left;
        int hold_left;
        int taken;
        res_ch.ready = 1'b0;
        run_left  = 0;
        hold_left = 0;
        taken     = 0;
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) begin
                taken++;
                if (taken == 150 || taken == 500) begin
                    hold_left = PRESSURE_CYCLES;
                    run_left  = 0;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                res_ch.ready <= 1'b1;
            end else begin
                run_left  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                       : $urandom_range(30, 120);
                hold_left = idle_len();
                if (hold_left > 0) begin
                    hold_left--;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stim_proc
        int         start_count;
        int         kind;
        int         len;
        logic [3:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [3:0] prev_idx;
        logic [7:0] prev_r;
        logic [7:0] prev_g;
        logic [7:0] prev_b;

        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = 1'b0;
        cmd_ch.entry_index = '0;
        cmd_ch.red         = '0;
        cmd_ch.green       = '0;
        cmd_ch.blue        = '0;
        cmd_ch.load_last   = 1'b0;
        prev_idx = 4'd2;
        prev_r   = 8'd190;
        prev_g   = 8'd26;
        prev_b   = 8'd36;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries against the reset palette
        send_word(CMD_QUERY, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_word(CMD_QUERY, 4'd15, 8'd255, 8'd255, 8'd255, 1'b1);
        send_word(CMD_QUERY, 4'd7, 8'd190, 8'd26, 8'd36, 1'b0);
        send_word(CMD_QUERY, 4'd0, 8'd48, 8'd230, 8'd198, 1'b0);
        send_word(CMD_QUERY, 4'd9, 8'd128, 8'd128, 8'd128, 1'b1);
        // loads that rewrite the stored value: revision stays put
        send_word(CMD_LOAD, 4'd2, 8'd190, 8'd26, 8'd36, 1'b1);
        send_word(CMD_LOAD, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_word(CMD_LOAD, 4'd15, 8'd164, 8'd167, 8'd162, 1'b1);
        // entry 3 made equal to entry 5: tie goes to the lower index
        send_word(CMD_LOAD, 4'd3, 8'd31, 8'd210, 8'd30, 1'b1);
        send_word(CMD_QUERY, 4'd5, 8'd31, 8'd210, 8'd30, 1'b0);
        // change early in a load, unchanged closing entry
        send_word(CMD_LOAD, 4'd5, 8'd0, 8'd0, 8'd0, 1'b0);
        send_word(CMD_LOAD, 4'd6, 8'd33, 8'd27, 8'd174, 1'b1);
        send_word(CMD_LOAD, 4'd1, 8'd0, 8'd0, 8'd0, 1'b0);
        send_word(CMD_QUERY, 4'd1, 8'd250, 8'd250, 8'd250, 1'b1);
        send_word(CMD_LOAD, 4'd1, 8'd255, 8'd255, 8'd255, 1'b1);
        send_word(CMD_QUERY, 4'd0, 8'd255, 8'd0, 8'd0, 1'b0);
        send_word(CMD_QUERY, 4'd0, 8'd0, 8'd0, 8'd255, 1'b0);
        send_word(CMD_QUERY, 4'd0, 8'd0, 8'd255, 8'd0, 1'b0);

        start_count = words_sent;
        while (words_sent - start_count < N_RANDOM) begin
            if ($urandom_range(0, 7) == 0) begin
                no_gaps = ~no_gaps;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                send_word(CMD_QUERY, 4'($urandom), pick_level(), pick_level(),
                          pick_level(), 1'($urandom));
            end else if (kind < 80) begin
                len = ($urandom_range(0, 9) == 0) ? PALETTE_SIZE : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    idx = (len == PALETTE_SIZE) ? 4'(k) : 4'($urandom);
                    r   = pick_level();
                    g   = pick_level();
                    b   = pick_level();
                    send_word(CMD_LOAD, idx, r, g, b, k == len - 1);
                end
                prev_idx = idx;
                prev_r   = r;
                prev_g   = g;
                prev_b   = b;
            end else if (kind < 88) begin
                // close a load with the value just stored
                send_word(CMD_LOAD, prev_idx, prev_r, prev_g, prev_b, 1'b1);
            end else if (kind < 93) begin
                // whole palette one corner color, query the opposite corner
                r = {8{1'($urandom)}};
                g = {8{1'($urandom)}};
                b = {8{1'($urandom)}};
                for (int k = 0; k < PALETTE_SIZE; k++) begin
                    send_word(CMD_LOAD, 4'(k), r, g, b, k == PALETTE_SIZE - 1);
                end
                send_word(CMD_QUERY, 4'($urandom), ~r, ~g, ~b, 1'($urandom));
            end else begin
                // lone write, load left open
                send_word(CMD_LOAD, 4'($urandom), pick_level(), pick_level(),
                          pick_level(), 1'b0);
            end
        end

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
